[hdl/room_placement_overlap_filter_unit_assert.svh]
// Assertion macros for the room placement overlap filter.
`ifndef ROOM_PLACEMENT_OVERLAP_FILTER_UNIT_ASSERT_SVH
`define ROOM_PLACEMENT_OVERLAP_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPOF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpof assertion failed");

// Next-cycle implication, disabled during reset.
`define RPOF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpof assertion failed");

`endif

[hdl/rpof_pkg.sv]
// Shared types and constants for the room placement overlap filter.
package rpof_pkg;

    localparam int COORD_BITS    = 10;
    localparam int LEVEL_BITS    = 4;
    localparam int MAX_ROOMS_DEF = 64;
    localparam int CNT_OUT_W     = 7;
    localparam int GAP           = 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] cand_x;
        logic [COORD_BITS-1:0] cand_y;
        logic [LEVEL_BITS-1:0] cand_level;
        logic [COORD_BITS-1:0] cand_width;
        logic [COORD_BITS-1:0] cand_height;
    } t_in;

    typedef struct packed {
        logic                 accepted;
        logic                 table_full;
        logic [CNT_OUT_W-1:0] room_count;
    } t_out;

endpackage

[hdl/rpof_table.sv]
// Room table memory: one write port, one registered read port.
module rpof_table #(
    parameter int DEPTH = rpof_pkg::MAX_ROOMS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  rpof_pkg::t_in i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output rpof_pkg::t_in o_rd_data
);

    rpof_pkg::t_in r_mem [DEPTH];
    rpof_pkg::t_in r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/rpof_touch.sv]
// Compare unit: does a stored room touch the candidate.
module rpof_touch (
    input  rpof_pkg::t_in i_cand,
    input  rpof_pkg::t_in i_room,
    output logic          o_hit
);

    localparam int SW = rpof_pkg::COORD_BITS + 2;

    // Sums are two bits wider than a coordinate, so they never wrap.
    function automatic logic spans_clash(
        input logic [rpof_pkg::COORD_BITS-1:0] a0,
        input logic [rpof_pkg::COORD_BITS-1:0] alen,
        input logic [rpof_pkg::COORD_BITS-1:0] b0,
        input logic [rpof_pkg::COORD_BITS-1:0] blen
    );
        logic [SW-1:0] a_end;
        logic [SW-1:0] b_end;
        a_end = SW'(a0) + SW'(alen) + SW'(rpof_pkg::GAP);
        b_end = SW'(b0) + SW'(blen) + SW'(rpof_pkg::GAP);
        return (SW'(a0) < b_end) && (SW'(b0) < a_end);
    endfunction

    assign o_hit = (i_cand.cand_level == i_room.cand_level)
        && spans_clash(i_cand.cand_x, i_cand.cand_width, i_room.cand_x, i_room.cand_width)
        && spans_clash(i_cand.cand_y, i_cand.cand_height, i_room.cand_y, i_room.cand_height);

endmodule

[hdl/room_placement_overlap_filter_unit.sv]
// Each item is taken in idle, then a scan reads the N stored rooms one a cycle, then
// the result is registered once the output is free. An empty or full table skips the scan.
// Input ready returns with the result valid, so one item is handled at a time.
// Reset (synchronous, active low) clears the room count, sequencer and output valid.
// Table contents are not cleared; only entries below the count are ever read.
// Top level of the room placement overlap filter.
`include "room_placement_overlap_filter_unit_assert.svh"

module room_placement_overlap_filter_unit #(
    parameter int MAX_ROOMS = rpof_pkg::MAX_ROOMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rpof_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rpof_pkg::t_out o_out_data
);

    localparam int AW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CW = $clog2(MAX_ROOMS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_rvld;
    logic           r_clash, n_clash;
    logic           r_full, n_full;
    logic           r_out_valid, n_out_valid;
    rpof_pkg::t_in  r_cand;
    rpof_pkg::t_out r_out;

    logic           w_issue;
    logic           w_hit;
    logic           w_out_free;
    logic           w_fin;
    logic           w_accept;
    logic           w_wr_en;
    rpof_pkg::t_in  w_rd_data;

    assign w_issue    = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fin      = (r_state == S_FINISH) && w_out_free;
    assign w_accept   = !r_full && !r_clash;
    assign w_wr_en    = w_fin && w_accept;

    rpof_table #(
        .DEPTH(MAX_ROOMS),
        .AW   (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(r_cand),
        .i_rd_en  (w_issue),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(w_rd_data)
    );

    rpof_touch u_touch (
        .i_cand(r_cand),
        .i_room(w_rd_data),
        .o_hit (w_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_clash     = r_clash;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_clash = 1'b0;
                    n_full  = (r_count >= CW'(MAX_ROOMS));
                    if ((r_count >= CW'(MAX_ROOMS)) || (r_count == '0)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rvld && w_hit) begin
                    n_clash = 1'b1;
                end
                // Advance once every entry is issued and the last compare is in.
                if (!w_issue && !r_rvld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (w_accept) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rvld      <= 1'b0;
            r_clash     <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rvld      <= w_issue;
            r_clash     <= n_clash;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_cand <= i_in_data;
        end
        if (w_fin) begin
            r_out.accepted   <= w_accept;
            r_out.table_full <= r_full;
            r_out.room_count <= rpof_pkg::CNT_OUT_W'(n_count);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RPOF_ASSERT_IMP(a_count_max, 1'b1, r_count <= CW'(MAX_ROOMS))
    `RPOF_ASSERT_IMP(a_flags_excl, o_out_valid, !(o_out_data.accepted && o_out_data.table_full))
    `RPOF_ASSERT_NXT(a_count_step, w_wr_en, r_count == CW'($past(r_count) + 1'b1))
    `RPOF_ASSERT_IMP(a_full_no_write, w_fin && r_full, !w_wr_en)

endmodule
